@@ sv/sbt_pkg.sv @@
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, codes and byte classes for the source byte tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int KIND_BITS       = 5;
	localparam int QUEUE_DEPTH     = 4;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_ID    = 4'd1,
		ST_INT   = 4'd2,
		ST_OP    = 4'd3,
		ST_STR   = 4'd4,
		ST_EQ    = 4'd5,
		ST_SLASH = 4'd6,
		ST_LCOM  = 4'd7,
		ST_BCOM  = 4'd8,
		ST_BSTAR = 4'd9
	} scan_state_t;

	typedef enum logic [KIND_BITS-1:0] {
		K_ID     = 5'd0,
		K_INT    = 5'd1,
		K_STR    = 5'd2,
		K_OP     = 5'd3,
		K_DEF    = 5'd4,
		K_EQUALS = 5'd5,
		K_LPAREN = 5'd6,
		K_RPAREN = 5'd7,
		K_LBRACE = 5'd8,
		K_RBRACE = 5'd9,
		K_LBRACK = 5'd10,
		K_RBRACK = 5'd11,
		K_COMMA  = 5'd12,
		K_COLON  = 5'd13,
		K_SEMI   = 5'd14,
		K_EOF    = 5'd15,
		K_UNTERM = 5'd16,
		K_BAD    = 5'd17
	} tok_kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_op(input logic [7:0] b);
		logic r;
		case (b)
			"+", "-", "*", "/", "%", "^", "|", "&", "=", "<", ">", "!": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// K_BAD marks a byte outside the punctuation set
	function automatic tok_kind_t punct_kind(input logic [7:0] b);
		tok_kind_t k;
		unique case (b)
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			",": k = K_COMMA;
			":": k = K_COLON;
			";": k = K_SEMI;
			default: k = K_BAD;
		endcase
		return k;
	endfunction

endpackage

@@ sv/source_byte_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// source_byte_tokenizer_core
// Streaming lexer: one source byte per beat in, tokens with position out.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle while the output queue has room. A byte
// is held in an input register, is classified against the scan state in a
// single pass, and its zero, one or two tokens enter a four-entry output
// queue, which is registered before its head is offered. The input stalls
// only while the output queue holds more than two tokens, so the sustained
// rate is one byte per cycle whenever tokens are drained at least as fast as
// they form. After the eof or an error token the block swallows further
// bytes without result until reset.
module source_byte_tokenizer_core #(
	parameter int OFFSET_BITS = sbt_pkg::OFFSET_BITS_DEF,
	parameter int COUNT_BITS  = sbt_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_ready,
	input  logic [7:0]                    in_byte,
	output logic                          token_valid,
	input  logic                          token_ready,
	output logic [sbt_pkg::KIND_BITS-1:0] token_kind,
	output logic [OFFSET_BITS-1:0]        token_start,
	output logic [COUNT_BITS-1:0]         token_length,
	output logic [COUNT_BITS-1:0]         token_line,
	output logic [COUNT_BITS-1:0]         token_column,
	output logic                          is_last
);

	localparam int QD = sbt_pkg::QUEUE_DEPTH;
	localparam int QCW = $clog2(QD + 1);
	localparam int QIW = $clog2(QD);
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
	localparam logic [COUNT_BITS-1:0] CNT_TWO = COUNT_BITS'(2);

	typedef struct packed {
		logic [sbt_pkg::KIND_BITS-1:0] kind;
		logic [OFFSET_BITS-1:0]        start;
		logic [COUNT_BITS-1:0]         length;
		logic [COUNT_BITS-1:0]         line;
		logic [COUNT_BITS-1:0]         column;
		logic                          last;
	} token_t;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  proc_fire;
	logic                  pop;

	sbt_pkg::scan_state_t  state_q, state_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	logic [COUNT_BITS-1:0] line_q, line_d;
	logic [COUNT_BITS-1:0] column_q, column_d;
	logic [OFFSET_BITS-1:0] pstart_q, pstart_d;
	logic [COUNT_BITS-1:0] plen_q, plen_d;
	logic [COUNT_BITS-1:0] pline_q, pline_d;
	logic [COUNT_BITS-1:0] pcol_q, pcol_d;
	logic                  halted_q, halted_d;

	logic                  pend_emit, idle_emit, to_idle;
	token_t                pend_tok, idle_tok;
	token_t                tok_a, tok_b;
	logic [1:0]            n_tok;

	token_t                queue_q [QD];
	token_t                queue_d [QD];
	logic [QCW-1:0]        count_q, count_d;

	assign proc_fire  = valid_s1 && (count_q <= QCW'(QD - 2));
	assign byte_ready = !valid_s1 || proc_fire;
	assign pop        = token_valid && token_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		logic [7:0] b;
		b         = byte_s1;
		state_d   = state_q;
		offset_d  = offset_q;
		line_d    = line_q;
		column_d  = column_q;
		pstart_d  = pstart_q;
		plen_d    = plen_q;
		pline_d   = pline_q;
		pcol_d    = pcol_q;
		halted_d  = halted_q;
		to_idle   = 1'b0;
		pend_emit = 1'b0;
		idle_emit = 1'b0;
		pend_tok  = '{kind: sbt_pkg::K_OP, start: pstart_q, length: plen_q,
			line: pline_q, column: pcol_q, last: 1'b0};
		idle_tok  = '{kind: sbt_pkg::K_EOF, start: offset_q, length: '0,
			line: line_q, column: column_q, last: 1'b0};

		if (!halted_q) begin
			unique case (state_q)
				sbt_pkg::ST_ID, sbt_pkg::ST_INT: begin
					if ((state_q == sbt_pkg::ST_ID) ? sbt_pkg::is_letter(b)
						: sbt_pkg::is_digit(b)) begin
						plen_d = (plen_q == '1) ? plen_q : plen_q + CNT_ONE;
					end else begin
						pend_emit     = 1'b1;
						pend_tok.kind = (state_q == sbt_pkg::ST_ID) ? sbt_pkg::K_ID
							: sbt_pkg::K_INT;
						to_idle       = 1'b1;
					end
				end
				sbt_pkg::ST_OP: begin
					if (sbt_pkg::is_op(b)) begin
						plen_d = (plen_q == '1) ? plen_q : plen_q + CNT_ONE;
					end else begin
						pend_emit = 1'b1;
						to_idle   = 1'b1;
					end
				end
				sbt_pkg::ST_STR: begin
					if (b == sbt_pkg::CH_QUOTE) begin
						pend_emit     = 1'b1;
						pend_tok.kind = sbt_pkg::K_STR;
						state_d       = sbt_pkg::ST_IDLE;
					end else if (b == sbt_pkg::CH_NUL) begin
						pend_emit     = 1'b1;
						pend_tok.kind = sbt_pkg::K_UNTERM;
						pend_tok.last = 1'b1;
						halted_d      = 1'b1;
					end else begin
						plen_d = (plen_q == '1) ? plen_q : plen_q + CNT_ONE;
					end
				end
				sbt_pkg::ST_EQ: begin
					if (b == sbt_pkg::CH_GT) begin
						plen_d          = CNT_TWO;
						pend_emit       = 1'b1;
						pend_tok.kind   = sbt_pkg::K_DEF;
						pend_tok.length = CNT_TWO;
						state_d         = sbt_pkg::ST_IDLE;
					end else if (b == sbt_pkg::CH_EQ) begin
						plen_d  = CNT_TWO;
						state_d = sbt_pkg::ST_OP;
					end else begin
						pend_emit     = 1'b1;
						pend_tok.kind = sbt_pkg::K_EQUALS;
						to_idle       = 1'b1;
					end
				end
				sbt_pkg::ST_SLASH: begin
					if (b == sbt_pkg::CH_SLASH) begin
						state_d = sbt_pkg::ST_LCOM;
					end else if (b == sbt_pkg::CH_STAR) begin
						state_d = sbt_pkg::ST_BCOM;
					end else if (sbt_pkg::is_op(b)) begin
						plen_d  = CNT_TWO;
						state_d = sbt_pkg::ST_OP;
					end else begin
						pend_emit = 1'b1;
						to_idle   = 1'b1;
					end
				end
				sbt_pkg::ST_LCOM: begin
					if (b == sbt_pkg::CH_LF || b == sbt_pkg::CH_NUL) begin
						to_idle = 1'b1;
					end
				end
				sbt_pkg::ST_BCOM, sbt_pkg::ST_BSTAR: begin
					if (b == sbt_pkg::CH_NUL) begin
						to_idle = 1'b1;
					end else if (b == sbt_pkg::CH_STAR) begin
						state_d = sbt_pkg::ST_BSTAR;
					end else if (b == sbt_pkg::CH_SLASH && state_q == sbt_pkg::ST_BSTAR) begin
						state_d = sbt_pkg::ST_IDLE;
					end else begin
						state_d = sbt_pkg::ST_BCOM;
					end
				end
				default: begin
					to_idle = 1'b1;
				end
			endcase

			if (to_idle) begin
				state_d = sbt_pkg::ST_IDLE;
				if (b == sbt_pkg::CH_NUL) begin
					halted_d      = 1'b1;
					idle_emit     = 1'b1;
					idle_tok.last = 1'b1;
				end else if (b == sbt_pkg::CH_SPACE || b == sbt_pkg::CH_TAB
					|| b == sbt_pkg::CH_CR || b == sbt_pkg::CH_LF) begin
					state_d = sbt_pkg::ST_IDLE;
				end else if (sbt_pkg::is_letter(b) || sbt_pkg::is_digit(b)
					|| b == sbt_pkg::CH_QUOTE || sbt_pkg::is_op(b)) begin
					pstart_d = offset_q;
					pline_d  = line_q;
					pcol_d   = column_q;
					plen_d   = (b == sbt_pkg::CH_QUOTE) ? '0 : CNT_ONE;
					if (sbt_pkg::is_letter(b)) begin
						state_d = sbt_pkg::ST_ID;
					end else if (sbt_pkg::is_digit(b)) begin
						state_d = sbt_pkg::ST_INT;
					end else if (b == sbt_pkg::CH_QUOTE) begin
						state_d = sbt_pkg::ST_STR;
					end else if (b == sbt_pkg::CH_EQ) begin
						state_d = sbt_pkg::ST_EQ;
					end else if (b == sbt_pkg::CH_SLASH) begin
						state_d = sbt_pkg::ST_SLASH;
					end else begin
						state_d = sbt_pkg::ST_OP;
					end
				end else begin
					idle_emit       = 1'b1;
					idle_tok.kind   = sbt_pkg::punct_kind(b);
					idle_tok.length = CNT_ONE;
					if (sbt_pkg::punct_kind(b) == sbt_pkg::K_BAD) begin
						idle_tok.last = 1'b1;
						halted_d      = 1'b1;
					end
				end
			end

			if (b != sbt_pkg::CH_NUL) begin
				offset_d = (offset_q == '1) ? offset_q : offset_q + OFFSET_BITS'(1);
				if (b == sbt_pkg::CH_TAB || b == sbt_pkg::CH_CR || b == sbt_pkg::CH_LF) begin
					column_d = CNT_ONE;
					if (b == sbt_pkg::CH_LF) begin
						line_d = (line_q == '1) ? line_q : line_q + CNT_ONE;
					end
				end else begin
					column_d = (column_q == '1) ? column_q : column_q + CNT_ONE;
				end
			end
		end

		tok_a = pend_emit ? pend_tok : idle_tok;
		tok_b = idle_tok;
		n_tok = 2'(pend_emit) + 2'(idle_emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sbt_pkg::ST_IDLE;
			offset_q <= '0;
			line_q   <= CNT_ONE;
			column_q <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			pline_q  <= CNT_ONE;
			pcol_q   <= '0;
			halted_q <= 1'b0;
		end else if (proc_fire) begin
			state_q  <= state_d;
			offset_q <= offset_d;
			line_q   <= line_d;
			column_q <= column_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			pline_q  <= pline_d;
			pcol_q   <= pcol_d;
			halted_q <= halted_d;
		end
	end

	always_comb begin
		queue_d = queue_q;
		count_d = count_q;
		if (pop) begin
			for (int i = 0; i < QD - 1; i++) begin
				queue_d[i] = queue_q[i + 1];
			end
			count_d = count_q - QCW'(1);
		end
		if (proc_fire) begin
			if (n_tok != 2'd0) begin
				queue_d[count_d[QIW-1:0]] = tok_a;
			end
			if (n_tok == 2'd2) begin
				queue_d[count_d[QIW-1:0] + QIW'(1)] = tok_b;
			end
			count_d = count_d + QCW'(n_tok);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		queue_q <= queue_d;
	end

	assign token_valid  = (count_q != '0);
	assign token_kind   = queue_q[0].kind;
	assign token_start  = queue_q[0].start;
	assign token_length = queue_q[0].length;
	assign token_line   = queue_q[0].line;
	assign token_column = queue_q[0].column;
	assign is_last      = queue_q[0].last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QD))
		else $error("token queue overflow");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	a_last_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_fire && n_tok != 2'd0 && (tok_a.last || (n_tok == 2'd2 && tok_b.last)))
		|=> halted_q)
		else $error("last token did not halt the scanner");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(halted_q && proc_fire) |-> n_tok == 2'd0)
		else $error("token produced while halted");

	a_room_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		proc_fire |=> count_q <= QCW'(QD))
		else $error("byte processed without queue room");

endmodule

@@ tb/token_stream_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches the byte and token channels of the tokenizer, lexes every accepted
// byte on its own and compares each token beat with the oldest token owed.
// ----------------------------------------------------------------------------
module token_stream_checker #(
	parameter int OFFSET_BITS = sbt_pkg::OFFSET_BITS_DEF,
	parameter int COUNT_BITS  = sbt_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	input  logic                          byte_ready,
	input  logic [7:0]                    in_byte,
	input  logic                          token_valid,
	input  logic                          token_ready,
	input  logic [sbt_pkg::KIND_BITS-1:0] token_kind,
	input  logic [OFFSET_BITS-1:0]        token_start,
	input  logic [COUNT_BITS-1:0]         token_length,
	input  logic [COUNT_BITS-1:0]         token_line,
	input  logic [COUNT_BITS-1:0]         token_column,
	input  logic                          is_last,
	output int                            mismatches,
	output int                            tokens_seen,
	output int                            tokens_owed
);

	typedef struct {
		sbt_pkg::tok_kind_t     kind;
		logic [OFFSET_BITS-1:0] start;
		logic [COUNT_BITS-1:0]  length;
		logic [COUNT_BITS-1:0]  line;
		logic [COUNT_BITS-1:0]  column;
		logic                   last;
	} token_t;

	token_t                 upcoming_tokens[$];
	sbt_pkg::scan_state_t   scan;
	logic [OFFSET_BITS-1:0] offset;
	logic [OFFSET_BITS-1:0] tok_start;
	logic [COUNT_BITS-1:0]  line_no;
	logic [COUNT_BITS-1:0]  column_no;
	logic [COUNT_BITS-1:0]  tok_len;
	logic [COUNT_BITS-1:0]  tok_line;
	logic [COUNT_BITS-1:0]  tok_column;
	logic                   stopped;
	int                     miss_count;
	int                     seen_count;

	function automatic logic letter_byte(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic digit_byte(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic opchar_byte(input logic [7:0] b);
		logic hit;
		case (b)
			"+", "-", "*", "/", "%", "^", "|", "&", "=", "<", ">", "!": hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic sbt_pkg::tok_kind_t punct_token(input logic [7:0] b);
		sbt_pkg::tok_kind_t k;
		case (b)
			"(": k = sbt_pkg::K_LPAREN;
			")": k = sbt_pkg::K_RPAREN;
			"{": k = sbt_pkg::K_LBRACE;
			"}": k = sbt_pkg::K_RBRACE;
			"[": k = sbt_pkg::K_LBRACK;
			"]": k = sbt_pkg::K_RBRACK;
			",": k = sbt_pkg::K_COMMA;
			":": k = sbt_pkg::K_COLON;
			";": k = sbt_pkg::K_SEMI;
			default: k = sbt_pkg::K_BAD;
		endcase
		return k;
	endfunction

	function automatic logic [COUNT_BITS-1:0] bump_count(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] bump_offset(input logic [OFFSET_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	task automatic push_token(input sbt_pkg::tok_kind_t k, input logic [OFFSET_BITS-1:0] s,
			input logic [COUNT_BITS-1:0] len, input logic [COUNT_BITS-1:0] ln,
			input logic [COUNT_BITS-1:0] col, input logic last);
		token_t t;
		t.kind   = k;
		t.start  = s;
		t.length = len;
		t.line   = ln;
		t.column = col;
		t.last   = last;
		upcoming_tokens.push_back(t);
	endtask

	task automatic push_pending(input sbt_pkg::tok_kind_t k, input logic last);
		push_token(k, tok_start, tok_len, tok_line, tok_column, last);
	endtask

	task automatic open_token(input sbt_pkg::scan_state_t st,
			input logic [COUNT_BITS-1:0] len);
		scan       = st;
		tok_start  = offset;
		tok_line   = line_no;
		tok_column = column_no;
		tok_len    = len;
	endtask

	task automatic lex_idle(input logic [7:0] b);
		sbt_pkg::tok_kind_t pk;
		scan = sbt_pkg::ST_IDLE;
		pk = punct_token(b);
		if (b == sbt_pkg::CH_NUL) begin
			stopped = 1'b1;
			push_token(sbt_pkg::K_EOF, offset, '0, line_no, column_no, 1'b1);
		end else if (b == sbt_pkg::CH_SPACE || b == sbt_pkg::CH_TAB
				|| b == sbt_pkg::CH_CR || b == sbt_pkg::CH_LF) begin
		end else if (letter_byte(b)) begin
			open_token(sbt_pkg::ST_ID, COUNT_BITS'(1));
		end else if (digit_byte(b)) begin
			open_token(sbt_pkg::ST_INT, COUNT_BITS'(1));
		end else if (b == sbt_pkg::CH_QUOTE) begin
			open_token(sbt_pkg::ST_STR, '0);
		end else if (b == sbt_pkg::CH_EQ) begin
			open_token(sbt_pkg::ST_EQ, COUNT_BITS'(1));
		end else if (b == sbt_pkg::CH_SLASH) begin
			open_token(sbt_pkg::ST_SLASH, COUNT_BITS'(1));
		end else if (opchar_byte(b)) begin
			open_token(sbt_pkg::ST_OP, COUNT_BITS'(1));
		end else if (pk != sbt_pkg::K_BAD) begin
			push_token(pk, offset, COUNT_BITS'(1), line_no, column_no, 1'b0);
		end else begin
			stopped = 1'b1;
			push_token(sbt_pkg::K_BAD, offset, COUNT_BITS'(1), line_no, column_no, 1'b1);
		end
	endtask

	task automatic lex_byte(input logic [7:0] b);
		logic reenter;
		reenter = 1'b0;
		if (!stopped) begin
			case (scan)
				sbt_pkg::ST_ID: begin
					if (letter_byte(b)) tok_len = bump_count(tok_len);
					else begin
						push_pending(sbt_pkg::K_ID, 1'b0);
						reenter = 1'b1;
					end
				end
				sbt_pkg::ST_INT: begin
					if (digit_byte(b)) tok_len = bump_count(tok_len);
					else begin
						push_pending(sbt_pkg::K_INT, 1'b0);
						reenter = 1'b1;
					end
				end
				sbt_pkg::ST_OP: begin
					if (opchar_byte(b)) tok_len = bump_count(tok_len);
					else begin
						push_pending(sbt_pkg::K_OP, 1'b0);
						reenter = 1'b1;
					end
				end
				sbt_pkg::ST_STR: begin
					if (b == sbt_pkg::CH_QUOTE) begin
						push_pending(sbt_pkg::K_STR, 1'b0);
						scan = sbt_pkg::ST_IDLE;
					end else if (b == sbt_pkg::CH_NUL) begin
						push_pending(sbt_pkg::K_UNTERM, 1'b1);
						stopped = 1'b1;
					end else begin
						tok_len = bump_count(tok_len);
					end
				end
				sbt_pkg::ST_EQ: begin
					if (b == sbt_pkg::CH_GT) begin
						tok_len = COUNT_BITS'(2);
						push_pending(sbt_pkg::K_DEF, 1'b0);
						scan = sbt_pkg::ST_IDLE;
					end else if (b == sbt_pkg::CH_EQ) begin
						tok_len = COUNT_BITS'(2);
						scan = sbt_pkg::ST_OP;
					end else begin
						push_pending(sbt_pkg::K_EQUALS, 1'b0);
						reenter = 1'b1;
					end
				end
				sbt_pkg::ST_SLASH: begin
					if (b == sbt_pkg::CH_SLASH) scan = sbt_pkg::ST_LCOM;
					else if (b == sbt_pkg::CH_STAR) scan = sbt_pkg::ST_BCOM;
					else if (opchar_byte(b)) begin
						tok_len = COUNT_BITS'(2);
						scan = sbt_pkg::ST_OP;
					end else begin
						push_pending(sbt_pkg::K_OP, 1'b0);
						reenter = 1'b1;
					end
				end
				sbt_pkg::ST_LCOM: begin
					if (b == sbt_pkg::CH_LF || b == sbt_pkg::CH_NUL) reenter = 1'b1;
				end
				sbt_pkg::ST_BCOM, sbt_pkg::ST_BSTAR: begin
					if (b == sbt_pkg::CH_NUL) reenter = 1'b1;
					else if (b == sbt_pkg::CH_STAR) scan = sbt_pkg::ST_BSTAR;
					else if (b == sbt_pkg::CH_SLASH && scan == sbt_pkg::ST_BSTAR)
						scan = sbt_pkg::ST_IDLE;
					else scan = sbt_pkg::ST_BCOM;
				end
				default: begin
					reenter = 1'b1;
				end
			endcase
			if (reenter) lex_idle(b);
			if (b != sbt_pkg::CH_NUL) begin
				offset = bump_offset(offset);
				if (b == sbt_pkg::CH_TAB || b == sbt_pkg::CH_CR || b == sbt_pkg::CH_LF) begin
					column_no = COUNT_BITS'(1);
					if (b == sbt_pkg::CH_LF) line_no = bump_count(line_no);
				end else begin
					column_no = bump_count(column_no);
				end
			end
		end
	endtask

	task automatic check_token();
		token_t want;
		seen_count++;
		if (upcoming_tokens.size() == 0) begin
			miss_count++;
			if (miss_count <= 10)
				$display("token %0d arrived with none owed: kind %0d start %0d len %0d",
					seen_count, token_kind, token_start, token_length);
		end else begin
			want = upcoming_tokens.pop_front();
			if (token_kind !== want.kind || token_start !== want.start ||
					token_length !== want.length || token_line !== want.line ||
					token_column !== want.column || is_last !== want.last) begin
				miss_count++;
				if (miss_count <= 10) begin
					$display({"token %0d mismatch: expected kind %0d start %0d len %0d",
						" line %0d col %0d last %0b"},
						seen_count, want.kind, want.start, want.length, want.line,
						want.column, want.last);
					$display("  actual kind %0d start %0d len %0d line %0d col %0d last %0b",
						token_kind, token_start, token_length, token_line, token_column,
						is_last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan        = sbt_pkg::ST_IDLE;
			offset      = '0;
			line_no     = COUNT_BITS'(1);
			column_no   = '0;
			tok_start   = '0;
			tok_len     = '0;
			tok_line    = COUNT_BITS'(1);
			tok_column  = '0;
			stopped     = 1'b0;
			miss_count  = 0;
			seen_count  = 0;
			upcoming_tokens.delete();
			mismatches  <= 0;
			tokens_seen <= 0;
			tokens_owed <= 0;
		end else begin
			if (byte_valid && byte_ready) lex_byte(in_byte);
			if (token_valid && token_ready) check_token();
			mismatches  <= miss_count;
			tokens_seen <= seen_count;
			tokens_owed <= upcoming_tokens.size();
		end
	end

endmodule

@@ tb/source_byte_tokenizer_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_byte_tokenizer_core_tb
// Feeds one source stream through the tokenizer: a short directed text, then
// random well-formed tokens with noise, closed by a random ending (eof in one of
// several scan states, unterminated string or bad byte) and a few bytes that the
// halted block must ignore. Both channels stall at random in the first two thirds.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_core_tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int STREAM_BYTES = 550;
	localparam int DRAIN_CYCLES = 20;

	logic                                clk;
	logic                                arst_n      = 1'b0;
	logic                                byte_valid  = 1'b0;
	logic                                byte_ready;
	logic [7:0]                          in_byte     = 8'h00;
	logic                                token_valid;
	logic                                token_ready = 1'b0;
	logic [sbt_pkg::KIND_BITS-1:0]       token_kind;
	logic [sbt_pkg::OFFSET_BITS_DEF-1:0] token_start;
	logic [sbt_pkg::COUNT_BITS_DEF-1:0]  token_length;
	logic [sbt_pkg::COUNT_BITS_DEF-1:0]  token_line;
	logic [sbt_pkg::COUNT_BITS_DEF-1:0]  token_column;
	logic                                is_last;
	int                                  mismatches;
	int                                  tokens_seen;
	int                                  tokens_owed;
	int                                  sender_idle_pct   = 22;
	int                                  receiver_idle_pct = 68;
	int                                  sent_bytes        = 0;
	int                                  cycles            = 0;
	logic [7:0]                          source_text[$];
	string                               ending;

	source_byte_tokenizer_core #(
		.OFFSET_BITS(sbt_pkg::OFFSET_BITS_DEF),
		.COUNT_BITS (sbt_pkg::COUNT_BITS_DEF)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.in_byte     (in_byte),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.token_line  (token_line),
		.token_column(token_column),
		.is_last     (is_last)
	);

	token_stream_checker #(
		.OFFSET_BITS(sbt_pkg::OFFSET_BITS_DEF),
		.COUNT_BITS (sbt_pkg::COUNT_BITS_DEF)
	) stream_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.in_byte     (in_byte),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.token_line  (token_line),
		.token_column(token_column),
		.is_last     (is_last),
		.mismatches  (mismatches),
		.tokens_seen (tokens_seen),
		.tokens_owed (tokens_owed)
	);

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic logic [7:0] blank_byte();
		logic [7:0] b;
		case ($urandom_range(3))
			0: b = sbt_pkg::CH_SPACE;
			1: b = sbt_pkg::CH_TAB;
			2: b = sbt_pkg::CH_CR;
			default: b = sbt_pkg::CH_LF;
		endcase
		return b;
	endfunction

	task automatic put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) source_text.push_back(s[i]);
	endtask

	task automatic put_gap();
		repeat ($urandom_range(2)) source_text.push_back(blank_byte());
	endtask

	task automatic put_ident(input int maxlen);
		repeat ($urandom_range(1, maxlen))
			source_text.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
	endtask

	task automatic put_digits();
		repeat ($urandom_range(1, 6)) source_text.push_back(pick("0123456789"));
	endtask

	task automatic put_op();
		if ($urandom_range(3) == 0) put_text("==");
		else source_text.push_back(pick("+-*%^|&<>!"));
		repeat ($urandom_range(3)) source_text.push_back(pick("+-*/%^|&=<>!"));
	endtask

	task automatic put_string(input logic closed);
		logic [7:0] b;
		source_text.push_back(sbt_pkg::CH_QUOTE);
		repeat ($urandom_range(8)) begin
			do b = 8'($urandom_range(1, 255)); while (b == sbt_pkg::CH_QUOTE);
			source_text.push_back(b);
		end
		if (closed) source_text.push_back(sbt_pkg::CH_QUOTE);
	endtask

	task automatic put_line_comment(input logic closed);
		logic [7:0] b;
		put_text(" //");
		repeat ($urandom_range(6)) begin
			do b = 8'($urandom_range(1, 255)); while (b == sbt_pkg::CH_LF);
			source_text.push_back(b);
		end
		if (closed) source_text.push_back(sbt_pkg::CH_LF);
	endtask

	task automatic put_block_comment(input logic closed);
		logic [7:0] b;
		put_text(" /*");
		if ($urandom_range(3) == 0) source_text.push_back(sbt_pkg::CH_SLASH);
		repeat ($urandom_range(8)) begin
			do b = 8'($urandom_range(1, 255)); while (b == sbt_pkg::CH_SLASH);
			source_text.push_back(b);
		end
		if (closed) put_text("*/");
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d bytes sent", cycles, sent_bytes);
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk)
		token_ready <= arst_n && ($urandom_range(99) >= receiver_idle_pct);

	initial begin
		int roll;
		int total;

		put_text("Zz_");
		source_text.push_back(sbt_pkg::CH_TAB);
		put_text("09\"");
		source_text.push_back(8'hFF);
		put_text("\"! =>=(){}[],:;/*/**/a/b");
		source_text.push_back(sbt_pkg::CH_LF);

		while (source_text.size() < STREAM_BYTES) begin
			roll = $urandom_range(99);
			if (roll < 18) put_ident(($urandom_range(15) == 0) ? 40 : 8);
			else if (roll < 30) put_digits();
			else if (roll < 40) put_string(1'b1);
			else if (roll < 52) put_op();
			else if (roll < 58) put_text("=>");
			else if (roll < 64) put_text("= ");
			else if (roll < 78) source_text.push_back(pick("(){}[],:;"));
			else if (roll < 82) begin
				put_text(" /");
				if ($urandom_range(1)) source_text.push_back(pick("+-%^|&=<>!"));
				put_text(" ");
			end else if (roll < 87) put_line_comment(1'b1);
			else if (roll < 93) put_block_comment(1'b1);
			else begin
				repeat ($urandom_range(1, 6))
					source_text.push_back(pick("aZ_09+-*%<>!=(){}[],:; "));
				put_text(" ");
			end
			put_gap();
		end

		put_text(" ");
		case ($urandom_range(9))
			0: begin
				ending = "eof between tokens";
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			1: begin
				ending = "eof after identifier";
				put_ident(8);
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			2: begin
				ending = "eof after integer";
				put_digits();
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			3: begin
				ending = "eof after operator run";
				put_op();
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			4: begin
				ending = "eof after equals";
				put_text("=");
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			5: begin
				ending = "eof after slash";
				put_text("/");
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			6: begin
				ending = "eof inside line comment";
				put_line_comment(1'b0);
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			7: begin
				ending = "eof inside block comment";
				put_block_comment(1'b0);
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			8: begin
				ending = "unterminated string";
				put_string(1'b0);
				source_text.push_back(sbt_pkg::CH_NUL);
			end
			default: begin
				ending = "bad byte";
				case ($urandom_range(2))
					0: source_text.push_back(pick("#$.?@`~\\'"));
					1: source_text.push_back(8'($urandom_range(1, 8)));
					default: source_text.push_back(8'($urandom_range(128, 255)));
				endcase
			end
		endcase
		repeat ($urandom_range(3, 8)) source_text.push_back(8'($urandom_range(255)));
		total = source_text.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_bytes < total) begin
			@(posedge clk);
			if (byte_valid && byte_ready) sent_bytes++;
			if (!byte_valid || byte_ready) begin
				if (sent_bytes < total && $urandom_range(99) >= sender_idle_pct) begin
					byte_valid <= 1'b1;
					in_byte    <= source_text[sent_bytes];
				end else begin
					byte_valid <= 1'b0;
				end
			end
			if (sent_bytes >= (2 * total) / 3) begin
				sender_idle_pct   <= 0;
				receiver_idle_pct <= 0;
			end else if (sent_bytes >= total / 3) begin
				sender_idle_pct   <= 68;
				receiver_idle_pct <= 22;
			end
		end

		while (tokens_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("stream of %0d bytes ending with %s, %0d tokens compared",
			sent_bytes, ending, tokens_seen);
		$display("%0d mismatched tokens, %0d tokens never delivered", mismatches, tokens_owed);
		if (mismatches == 0 && tokens_owed == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
